// ===== src/rsx_pkg.sv =====
// Shared constants, types and helper functions for the instruction executor.
package rsx_pkg;

  localparam int NUM_REGS   = 16;
  localparam int MEM_WORDS  = 16;   // power of two: address is the low bits of the sum
  localparam int DATA_WIDTH = 16;

  localparam int REG_AW = $clog2(NUM_REGS);
  localparam int MEM_AW = $clog2(MEM_WORDS);

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // funct codes, register format
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_XOR = 6'd38;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [REG_AW-1:0]     reg_addr_t;
  typedef logic [MEM_AW-1:0]     mem_addr_t;

  typedef struct packed {
    logic      en;
    reg_addr_t addr;
    data_t     data;
  } reg_wr_t;

  typedef struct packed {
    logic      en;
    mem_addr_t addr;
    data_t     data;
  } mem_wr_t;

  // 5-bit register field reduced modulo NUM_REGS (restoring reduction, 5 steps)
  function automatic reg_addr_t reg_sel(input logic [4:0] v);
    logic [9:0] r;
    logic [9:0] lim;
    r = 10'(v);
    for (int k = 4; k >= 0; k--) begin
      lim = 10'(NUM_REGS) << k;
      if (r >= lim) begin
        r = r - lim;
      end
    end
    return REG_AW'(r);
  endfunction

  // power-on contents: entry i holds i
  function automatic data_t reg_init(input reg_addr_t idx);
    return DATA_WIDTH'(idx);
  endfunction

  function automatic data_t mem_init(input mem_addr_t idx);
    return DATA_WIDTH'(idx);
  endfunction

endpackage

// ===== src/rsx_regfile.sv =====
// Register file: two synchronous read ports, one write port, per-entry valid bits.
module rsx_regfile
  import rsx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      rd_en,
  input  reg_addr_t rd_a_addr,
  input  reg_addr_t rd_b_addr,
  output data_t     rd_a_data,
  output data_t     rd_b_data,
  input  reg_wr_t   wr
);

  data_t               mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;

  data_t     a_q, b_q;
  logic      a_vld, b_vld;
  reg_addr_t a_addr, b_addr;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      a_q    <= mem[rd_a_addr];
      b_q    <= mem[rd_b_addr];
      a_vld  <= vld[rd_a_addr];
      b_vld  <= vld[rd_b_addr];
      a_addr <= rd_a_addr;
      b_addr <= rd_b_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  // unwritten entries read as their reset value
  assign rd_a_data = a_vld ? a_q : reg_init(a_addr);
  assign rd_b_data = b_vld ? b_q : reg_init(b_addr);

endmodule

// ===== src/rsx_dmem.sv =====
// Data memory: one synchronous read port, one write port, per-word valid bits.
module rsx_dmem
  import rsx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      rd_en,
  input  mem_addr_t rd_addr,
  output data_t     rd_data,
  input  mem_wr_t   wr
);

  data_t                mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld;

  data_t     rd_q;
  logic      rd_vld;
  mem_addr_t rd_addr_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_vld    <= vld[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_q : mem_init(rd_addr_q);

endmodule

// ===== src/risc_subset_instruction_executor_unit.sv =====
// Timing: an accepted instruction is registered into S1 and then into S2, where
//   result_valid is raised; result_stall can hold it in either stage.
// Throughput: one instruction per cycle while result_stall is low; set by the register file
//   read in the accept cycle and the data memory read in the execute cycle.
// Reset: rst (sync, active high) empties the pipeline and clears the valid bits,
//   so every register and memory word reads as its own index until written.
module risc_subset_instruction_executor_unit
  import rsx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // instruction channel
  input  logic        instr_valid,
  output logic        instr_stall,
  input  logic [31:0] instruction_word,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        is_r_format,
  output logic        reg_write,
  output logic [3:0]  reg_index,
  output logic [15:0] reg_value,
  output logic        mem_write,
  output logic [3:0]  mem_index,
  output logic [15:0] mem_value,
  output logic        bne_flag,
  output logic        recognized
);

  // ---------------------------------------------------------------------------
  // Pipeline
  //   accept : register file read issued with rs/rt of the incoming word
  //   S1     : decode, operand forwarding, ALU, address; data memory read or
  //            store issued at the S1 -> S2 edge
  //   S2     : output stage; load data arrives here; register write-back at
  //            the edge the result transaction completes
  // S2 moves when the output stage is free or drained; an empty S1 also accepts while S2 is stalled.
  // ---------------------------------------------------------------------------

  logic        s1_valid;
  logic [31:0] s1_instr;

  logic      s2_valid;
  logic      s2_rfmt, s2_rw, s2_lw, s2_mw, s2_bne, s2_rec;
  reg_addr_t s2_ri;
  data_t     s2_alu;
  mem_addr_t s2_mi;
  data_t     s2_mv;

  reg_wr_t wb;       // most recent register write, covers read-during-write
  reg_wr_t rf_wr;
  mem_wr_t dm_wr;

  logic  adv, accept, deliver;
  data_t rf_a, rf_b, dm_rdata, s2_rv;

  assign deliver     = s2_valid && !result_stall;
  assign adv         = !s2_valid || !result_stall;
  assign instr_stall = s1_valid && !adv;
  assign accept      = instr_valid && !instr_stall;

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  rsx_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_a_addr (reg_sel(instruction_word[25:21])),
    .rd_b_addr (reg_sel(instruction_word[20:16])),
    .rd_a_data (rf_a),
    .rd_b_data (rf_b),
    .wr        (rf_wr)
  );

  // ---------------------------------------------------------------------------
  // S1: decode and execute
  // ---------------------------------------------------------------------------
  logic [5:0] op, fn;
  reg_addr_t  rs, rt, rd;
  data_t      imm, a, b, sum_ai;
  mem_addr_t  addr;

  logic      x_rfmt, x_rw, x_lw, x_mw, x_bne, x_rec;
  reg_addr_t x_ri;
  data_t     x_alu;

  assign op  = s1_instr[31:26];
  assign fn  = s1_instr[5:0];
  assign rs  = reg_sel(s1_instr[25:21]);
  assign rt  = reg_sel(s1_instr[20:16]);
  assign rd  = reg_sel(s1_instr[15:11]);
  assign imm = DATA_WIDTH'({{32{s1_instr[15]}}, s1_instr[15:0]});

  // Operand forwarding: the instruction in S2 has not written back yet, and
  // the write that landed on the same edge as our read was missed by it.
  assign a = (s2_valid && s2_rw && s2_ri == rs) ? s2_rv :
             (wb.en && wb.addr == rs)            ? wb.data : rf_a;
  assign b = (s2_valid && s2_rw && s2_ri == rt) ? s2_rv :
             (wb.en && wb.addr == rt)            ? wb.data : rf_b;

  assign sum_ai = a + imm;
  assign addr   = MEM_AW'(sum_ai);

  always_comb begin
    x_rfmt = (op == OP_RTYPE);
    x_rw   = 1'b0;
    x_lw   = 1'b0;
    x_mw   = 1'b0;
    x_bne  = 1'b0;
    x_rec  = 1'b0;
    x_ri   = '0;
    x_alu  = '0;
    if (x_rfmt) begin
      x_ri  = rd;
      x_rec = 1'b1;
      case (fn)
        FN_ADD:  x_alu = a + b;
        FN_SUB:  x_alu = a - b;
        FN_AND:  x_alu = a & b;
        FN_OR:   x_alu = a | b;
        FN_XOR:  x_alu = a ^ b;
        default: x_rec = 1'b0;
      endcase
      x_rw = x_rec;
      if (!x_rec) begin
        x_ri  = '0;
        x_alu = '0;
      end
    end else begin
      case (op)
        OP_ADDI: begin
          x_rec = 1'b1;
          x_rw  = 1'b1;
          x_ri  = rt;
          x_alu = sum_ai;
        end
        OP_LW: begin
          x_rec = 1'b1;
          x_rw  = 1'b1;
          x_lw  = 1'b1;
          x_ri  = rt;
        end
        OP_SW: begin
          x_rec = 1'b1;
          x_mw  = 1'b1;
        end
        OP_BNE: begin
          x_rec = 1'b1;
          x_bne = 1'b1;
        end
        default: x_rec = 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Data memory: loads read and stores write as S1 moves to S2. Only one
  // instruction is in S1, so a load never races a store on the same edge.
  // ---------------------------------------------------------------------------
  assign dm_wr.en   = adv && s1_valid && x_mw;
  assign dm_wr.addr = addr;
  assign dm_wr.data = b;

  rsx_dmem u_dmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (adv && s1_valid && x_lw),
    .rd_addr (addr),
    .rd_data (dm_rdata),
    .wr      (dm_wr)
  );

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= instruction_word;
    end
    if (adv) begin
      s2_rfmt <= x_rfmt;
      s2_rw   <= x_rw;
      s2_lw   <= x_lw;
      s2_mw   <= x_mw;
      s2_bne  <= x_bne;
      s2_rec  <= x_rec;
      s2_ri   <= x_ri;
      s2_alu  <= x_alu;
      s2_mi   <= (x_lw || x_mw) ? addr : '0;
      s2_mv   <= x_mw ? b : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // S2: write-back on delivery
  // ---------------------------------------------------------------------------
  assign s2_rv = s2_lw ? dm_rdata : s2_alu;

  assign rf_wr.en   = deliver && s2_rw;
  assign rf_wr.addr = s2_ri;
  assign rf_wr.data = s2_rv;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb.en <= 1'b0;
    end else if (rf_wr.en) begin
      wb.en <= 1'b1;
    end
    if (rf_wr.en) begin
      wb.addr <= rf_wr.addr;
      wb.data <= rf_wr.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Result transaction
  // ---------------------------------------------------------------------------
  assign result_valid = s2_valid;
  assign is_r_format  = s2_rfmt;
  assign reg_write    = s2_rw;
  assign reg_index    = 4'(s2_ri);
  assign reg_value    = 16'(s2_rv);
  assign mem_write    = s2_mw;
  assign mem_index    = 4'(s2_mi);
  assign mem_value    = 16'(s2_mv);
  assign bne_flag     = s2_bne;
  assign recognized   = s2_rec;

`ifndef SYNTH
  // input is held off only when both stages are full and the output is stalled
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    instr_stall |-> (s1_valid && s2_valid && result_stall))
    else $error("instruction stalled with room in the pipeline");

  // a result appears only from an instruction that sat in S1
  a_s2_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(s2_valid) |-> $past(s1_valid))
    else $error("result without a preceding instruction");

  // a delivered register write is what forwarding sees on the next cycle
  a_wb_tracks: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |=> (wb.en && wb.addr == $past(s2_ri) && wb.data == $past(s2_rv)))
    else $error("write-back bypass out of step with the register file");

  // a branch flag never comes with a register or memory write
  a_bne_no_write: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bne_flag) |-> (!reg_write && !mem_write))
    else $error("bne result with a state write");
`endif

endmodule
